### hw/rtl/nls_pkg.sv
// Shared types and constants of the number literal scanner.
`timescale 1ns / 1ps

package nls_pkg;

  // Field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned TabW   = 4;
  localparam int unsigned ValueW = 64;
  localparam int unsigned LineW  = 24;
  localparam int unsigned ColW   = 16;
  localparam int unsigned DigitW = 4;

  // Defaults for top-level parameters
  localparam int unsigned DefValueBits  = 64;
  localparam int unsigned DefQueueDepth = 4;

  // Reset values
  localparam logic [TabW-1:0]  TabReset  = TabW'(4);
  localparam logic [LineW-1:0] LineReset = LineW'(1);
  localparam logic [LineW-1:0] LineMax   = '1;
  localparam logic [ColW-1:0]  ColMax    = '1;

  // Characters of interest
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChX     = 8'h78;
  localparam logic [CharW-1:0] ChXUp   = 8'h58;

  // Classified character as it travels from the front end to the back end
  typedef struct packed {
    logic              eoi;     // end of stream marker
    logic              ws;      // space, tab, CR or LF
    logic              zero;    // '0'
    logic              xch;     // 'x' or 'X'
    logic              dec_ok;  // '0'..'9'
    logic              oct_ok;  // '0'..'7'
    logic              hex_ok;  // '0'..'9', 'a'..'f', 'A'..'F'
    logic [DigitW-1:0] digit;   // digit value when one of the above holds
    logic [LineW-1:0]  line;    // line after this character
    logic [ColW-1:0]   col;     // column after this character
  } nls_item_t;

endpackage

### hw/rtl/nls_channels_if.sv
// Handshake channels of the number literal scanner: input, configuration, result.
`timescale 1ns / 1ps

interface nls_in_if;
  logic                      valid;
  logic                      ready;
  logic [nls_pkg::CharW-1:0] character;
  logic                      end_of_input;

  modport source (output valid, output character, output end_of_input, input ready);
  modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

interface nls_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [nls_pkg::TabW-1:0] tab_width;

  modport source (output valid, output tab_width, input ready);
  modport sink   (input valid, input tab_width, output ready);
endinterface

interface nls_out_if;
  logic                       valid;
  logic                       ready;
  logic [nls_pkg::ValueW-1:0] value;
  logic                       is_error;
  logic [nls_pkg::LineW-1:0]  line_number;
  logic [nls_pkg::ColW-1:0]   column_number;
  logic                       last;

  modport source (output valid, output value, output is_error, output line_number,
                  output column_number, output last, input ready);
  modport sink   (input valid, input value, input is_error, input line_number,
                  input column_number, input last, output ready);
endinterface

### hw/rtl/number_literal_scanner_top.sv
// Top level of the number literal scanner.
`timescale 1ns / 1ps

// Scans unsigned C integer literals (decimal, octal with a leading 0, hex with
// 0x/0X) from a byte stream, one character per beat, and reports each literal
// with its line and column; a character that cannot start a token gives an
// error beat. The input takes one character per cycle while the internal queue
// (QUEUE_DEPTH entries) has room. Behind the queue, the back end sends one
// result beat per cycle through its output register while the result side is
// ready; a character that both ends a literal and is an illegal start (two
// beats) holds the queue head until both are loaded. tab_width may only be
// written while the block is idle. No start-up sequence after reset.
module number_literal_scanner_top #(
  parameter int unsigned VALUE_BITS  = nls_pkg::DefValueBits,
  parameter int unsigned QUEUE_DEPTH = nls_pkg::DefQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nls_in_if.sink    in_i,
  nls_cfg_if.sink   cfg_i,
  nls_out_if.source out_o
);
  import nls_pkg::*;

  nls_item_t front_item, head_item;
  logic      push, full, pop, head_valid;

  nls_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  nls_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  nls_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .item_i       (head_item),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

### hw/rtl/nls_front.sv
// Front end: accepts characters, classifies them and tracks line and column.
`timescale 1ns / 1ps

module nls_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  nls_in_if.sink             in_i,
  nls_cfg_if.sink            cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output nls_pkg::nls_item_t item_o
);
  import nls_pkg::*;

  logic [TabW-1:0]  tab_q;
  logic [LineW-1:0] line_q, line_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [ColW:0]    col_sum;
  logic [CharW-1:0] ch;
  logic             is_tab;
  logic             is_letter;

  // Accept whenever the queue has room; configuration is always taken
  assign in_i.ready  = !full_i;
  assign push_o      = in_i.valid && !full_i;
  assign cfg_i.ready = 1'b1;

  assign ch     = in_i.character;
  assign is_tab = (ch == ChTab);

  // Column step, saturating
  assign col_sum = {1'b0, col_q} + (is_tab ? (ColW+1)'(tab_q) : (ColW+1)'(1));

  // Position after this character; an end marker leaves it alone
  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (!in_i.end_of_input) begin
      if (ch == ChLf) begin
        if (line_q != LineMax) line_d = line_q + LineW'(1);
        col_d = '0;
      end else if (ch != ChCr) begin
        col_d = col_sum[ColW] ? ColMax : col_sum[ColW-1:0];
      end
    end
  end

  // Character classes
  assign is_letter     = (ch inside {[8'h61:8'h66], [8'h41:8'h46]});
  assign item_o.eoi    = in_i.end_of_input;
  assign item_o.ws     = (ch == ChSpace) || is_tab || (ch == ChCr) || (ch == ChLf);
  assign item_o.zero   = (ch == ChZero);
  assign item_o.xch    = (ch == ChX) || (ch == ChXUp);
  assign item_o.dec_ok = (ch inside {[8'h30:8'h39]});
  assign item_o.oct_ok = (ch inside {[8'h30:8'h37]});
  assign item_o.hex_ok = item_o.dec_ok || is_letter;
  assign item_o.digit  = is_letter ? (ch[DigitW-1:0] + DigitW'(9)) : ch[DigitW-1:0];
  assign item_o.line   = line_d;
  assign item_o.col    = col_d;

  // Position counters and tab width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q  <= TabReset;
      line_q <= LineReset;
      col_q  <= '0;
    end else begin
      if (cfg_i.valid) tab_q <= cfg_i.tab_width;
      if (push_o) begin
        line_q <= line_d;
        col_q  <= col_d;
      end
    end
  end

endmodule

### hw/rtl/nls_fifo.sv
// Short queue of classified characters between front and back end.
`timescale 1ns / 1ps

module nls_fifo #(
  parameter int unsigned DEPTH = nls_pkg::DefQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  nls_pkg::nls_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output nls_pkg::nls_item_t item_o
);
  import nls_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  nls_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) count_q <= count_q + CntW'(1);
      else if (!do_push && do_pop) count_q <= count_q - CntW'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

### hw/rtl/nls_back.sv
// Back end: literal scanner with accumulator and registered result beat.
`timescale 1ns / 1ps

module nls_back #(
  parameter int unsigned VALUE_BITS = nls_pkg::DefValueBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  nls_pkg::nls_item_t item_i,
  output logic               pop_o,
  nls_out_if.source          out_o
);
  import nls_pkg::*;

  // Scan phase and number base codes
  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhZero   = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;
  localparam logic [1:0] BaseOct  = 2'd0;
  localparam logic [1:0] BaseDec  = 2'd1;
  localparam logic [1:0] BaseHex  = 2'd2;

  logic [1:0]            phase_q, phase_d;
  logic [1:0]            base_q, base_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [VALUE_BITS-1:0] acc_mul, acc_step;
  logic                  second_q;
  logic                  out_valid_q;
  logic [ValueW-1:0]     value_q;
  logic                  err_q, last_q;
  logic [LineW-1:0]      line_q;
  logic [ColW-1:0]       col_q;
  logic                  in_base, lit_emit, err_emit, examine;
  logic                  two, any, out_free, load, send_err;

  // Digit test and multiply-accumulate for the current base
  always_comb begin
    case (base_q)
      BaseHex: begin
        in_base = item_i.hex_ok;
        acc_mul = acc_q << 4;
      end
      BaseDec: begin
        in_base = item_i.dec_ok;
        acc_mul = (acc_q << 3) + (acc_q << 1);
      end
      default: begin
        in_base = item_i.oct_ok;
        acc_mul = acc_q << 3;
      end
    endcase
  end

  assign acc_step = acc_mul + VALUE_BITS'(item_i.digit);

  // Scanner next state and result decision for the head character
  always_comb begin
    phase_d  = phase_q;
    base_d   = base_q;
    acc_d    = acc_q;
    lit_emit = 1'b0;
    err_emit = 1'b0;
    examine  = 1'b0;
    if (item_i.eoi) begin
      lit_emit = (phase_q == PhZero) || (phase_q == PhDigits);
      phase_d  = PhIdle;
      base_d   = BaseOct;
      acc_d    = '0;
    end else begin
      case (phase_q)
        PhZero: begin
          if (item_i.xch) begin
            phase_d = PhDigits;
            base_d  = BaseHex;
            acc_d   = '0;
          end else if (item_i.oct_ok) begin
            phase_d = PhDigits;
            base_d  = BaseOct;
            acc_d   = VALUE_BITS'(item_i.digit);
          end else begin
            lit_emit = 1'b1;
            examine  = 1'b1;
          end
        end
        PhDigits: begin
          if (in_base) begin
            acc_d = acc_step;
          end else begin
            lit_emit = 1'b1;
            examine  = 1'b1;
          end
        end
        default: examine = 1'b1;
      endcase
      // Terminator or idle character looked at as a token start
      if (examine) begin
        phase_d = PhIdle;
        if (item_i.ws) begin
          phase_d = PhIdle;
        end else if (item_i.zero) begin
          phase_d = PhZero;
          base_d  = BaseOct;
          acc_d   = '0;
        end else if (item_i.dec_ok) begin
          phase_d = PhDigits;
          base_d  = BaseDec;
          acc_d   = VALUE_BITS'(item_i.digit);
        end else begin
          acc_d    = '0;
          err_emit = 1'b1;
        end
      end
    end
  end

  // Beat sequencing: a character with two results holds the head for two beats
  assign two      = lit_emit && err_emit;
  assign any      = lit_emit || err_emit;
  assign out_free = !out_valid_q || out_o.ready;
  assign load     = head_valid_i && out_free && any;
  assign pop_o    = head_valid_i && (any ? (out_free && (second_q || !two)) : 1'b1);
  assign send_err = second_q || !lit_emit;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      base_q      <= BaseOct;
      acc_q       <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        base_q  <= base_d;
        acc_q   <= acc_d;
      end
      if (load) second_q <= second_q ? 1'b0 : two;
      if (load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= send_err ? '0 : ValueW'(acc_q);
      err_q   <= send_err;
      last_q  <= send_err || !two;
      line_q  <= item_i.line;
      col_q   <= item_i.col;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.value         = value_q;
  assign out_o.is_error      = err_q;
  assign out_o.line_number   = line_q;
  assign out_o.column_number = col_q;
  assign out_o.last          = last_q;

endmodule

### hw/rtl/nls_checker.sv
// Port-level checks on the result channel of the number literal scanner.
`timescale 1ns / 1ps

module nls_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [nls_pkg::ValueW-1:0] out_value_i,
  input logic                       out_is_error_i,
  input logic [nls_pkg::LineW-1:0]  out_line_i,
  input logic                       out_last_i
);
  import nls_pkg::*;

  // A stalled beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // Error beats carry a zero value and close their character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_is_error_i |-> out_value_i == '0 && out_last_i)
    else $error("malformed error beat");

  // A literal that is not last is followed at once by its error beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_is_error_i && out_last_i)
    else $error("missing error beat after literal");

  // Line counting starts at one and saturates, never reaching zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_line_i != '0)
    else $error("line number zero");

endmodule

bind number_literal_scanner_top nls_checker u_nls_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_value_i    (out_o.value),
  .out_is_error_i (out_o.is_error),
  .out_line_i     (out_o.line_number),
  .out_last_i     (out_o.last)
);

### test/tb_top.sv
// Self-checking testbench of number_literal_scanner_top: directed rows, then random streams.
`timescale 1ns / 1ps

module tb_top;
  import nls_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DIR_ROWS     = 25;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_ZERO, SCAN_DIGITS} scan_phase_e;
  typedef enum logic [1:0] {RADIX_OCT, RADIX_DEC, RADIX_HEX} radix_e;

  // One result beat as the scanner should report it
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              is_error;
    logic [LineW-1:0]  line;
    logic [ColW-1:0]   col;
    logic              last;
  } lit_result_t;

  // Directed row: typed = 1 means the single result below is known by eye
  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic              eoi;
    logic              typed;
    logic [ValueW-1:0] value;
    logic              is_error;
    logic [LineW-1:0]  line;
    logic [ColW-1:0]   col;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{"@",     1'b0, 1'b1, 64'h0,  1'b1, 24'd1, 16'd1},  // illegal start straight after reset
    '{"0",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{"x",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{"F",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{"f",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{ChSpace, 1'b0, 1'b1, 64'hFF, 1'b0, 24'd1, 16'd6},  // hex 0xFf ended by a space
    '{ChTab,   1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{"9",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{ChCr,    1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},  // CR ends the literal, no column
    '{ChLf,    1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{"0",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{"8",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},  // octal prefix, then decimal restart
    '{8'hA5,   1'b1, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},  // end of stream flushes the 8
    '{8'hFF,   1'b0, 1'b1, 64'h0,  1'b1, 24'd2, 16'd3},  // top-bit byte is illegal
    '{"0",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{"X",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{"g",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},  // bare 0X, then error: two beats
    '{"0",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{"7",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{8'h00,   1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},  // octal 7, then NUL error
    '{"0",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{8'h5A,   1'b1, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},  // lone 0 flushed
    '{"0",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{"x",     1'b0, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0},
    '{8'h00,   1'b1, 1'b0, 64'h0,  1'b0, 24'd0, 16'd0}   // lone 0x flushed
  };

  logic clk;
  logic rst_n;

  nls_in_if  in_ch ();
  nls_cfg_if cfg_ch ();
  nls_out_if out_ch ();

  number_literal_scanner_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  // Scanner state as predicted
  scan_phase_e      scan_phase = SCAN_IDLE;
  radix_e           scan_radix = RADIX_OCT;
  logic [ValueW-1:0] scan_acc  = '0;
  logic [LineW-1:0] scan_line  = LineReset;
  logic [ColW-1:0]  scan_col   = '0;
  logic [TabW-1:0]  tab_cur    = TabReset;

  lit_result_t pending_lits[$];

  bit          no_gaps    = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned cycles     = 0;
  int unsigned n_fail     = 0;
  int unsigned n_beats    = 0;
  int unsigned n_results  = 0;
  int unsigned n_err_out  = 0;
  int unsigned n_cfg      = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%t: timeout with %0d results outstanding", $time, pending_lits.size());
      $display("number_literal_scanner_top regression: fail");
      $finish;
    end
  end

  function automatic bit is_ws(input logic [CharW-1:0] ch);
    return ch == ChSpace || ch == ChTab || ch == ChCr || ch == ChLf;
  endfunction

  // Digit value of ch in radix r, -1 when it is not one
  function automatic int digit_of_char(input logic [CharW-1:0] ch, input radix_e r);
    bit dec;
    dec = ch >= "0" && ch <= "9";
    case (r)
      RADIX_HEX: begin
        if (dec) return int'(ch - ChZero);
        if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
        if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
        return -1;
      end
      RADIX_DEC: return dec ? int'(ch - ChZero) : -1;
      default:   return (ch >= "0" && ch <= "7") ? int'(ch - ChZero) : -1;
    endcase
  endfunction

  function automatic logic [ValueW-1:0] radix_num(input radix_e r);
    case (r)
      RADIX_HEX: return 64'd16;
      RADIX_DEC: return 64'd10;
      default:   return 64'd8;
    endcase
  endfunction

  function automatic lit_result_t make_lit(input logic [ValueW-1:0] v, input logic err);
    lit_result_t res;
    res.value    = v;
    res.is_error = err;
    res.line     = scan_line;
    res.col      = scan_col;
    res.last     = 1'b0;
    return res;
  endfunction

  // Works out the result beats of one accepted character and queues them
  task automatic lex_char(input logic [CharW-1:0] ch, input logic eoi);
    lit_result_t res[$];
    int          d;
    bit          restart;
    logic [ColW:0] col_sum;
    if (eoi) begin
      if (scan_phase != SCAN_IDLE) res.push_back(make_lit(scan_acc, 1'b0));
      scan_phase = SCAN_IDLE;
      scan_radix = RADIX_OCT;
      scan_acc   = '0;
    end else begin
      // position after this character
      if (ch == ChLf) begin
        if (scan_line != LineMax) scan_line++;
        scan_col = '0;
      end else if (ch != ChCr) begin
        col_sum  = {1'b0, scan_col} + ((ch == ChTab) ? (ColW+1)'(tab_cur) : (ColW+1)'(1));
        scan_col = (col_sum > {1'b0, ColMax}) ? ColMax : col_sum[ColW-1:0];
      end
      restart = 1'b1;
      case (scan_phase)
        SCAN_ZERO: begin
          d = digit_of_char(ch, RADIX_OCT);
          if (ch == ChX || ch == ChXUp) begin
            scan_phase = SCAN_DIGITS;
            scan_radix = RADIX_HEX;
            scan_acc   = '0;
            restart    = 1'b0;
          end else if (d >= 0) begin
            scan_phase = SCAN_DIGITS;
            scan_radix = RADIX_OCT;
            scan_acc   = ValueW'(d);
            restart    = 1'b0;
          end else begin
            res.push_back(make_lit(scan_acc, 1'b0));
            scan_phase = SCAN_IDLE;
          end
        end
        SCAN_DIGITS: begin
          d = digit_of_char(ch, scan_radix);
          if (d >= 0) begin
            scan_acc = scan_acc * radix_num(scan_radix) + ValueW'(d);
            restart  = 1'b0;
          end else begin
            res.push_back(make_lit(scan_acc, 1'b0));
            scan_phase = SCAN_IDLE;
          end
        end
        default: scan_phase = SCAN_IDLE;
      endcase
      // terminator or idle character looked at as a token start
      if (restart && !is_ws(ch)) begin
        if (ch == ChZero) begin
          scan_phase = SCAN_ZERO;
          scan_radix = RADIX_OCT;
          scan_acc   = '0;
        end else if (ch >= "1" && ch <= "9") begin
          scan_phase = SCAN_DIGITS;
          scan_radix = RADIX_DEC;
          scan_acc   = ValueW'(ch - ChZero);
        end else begin
          scan_acc = '0;
          res.push_back(make_lit('0, 1'b1));
        end
      end
    end
    if (res.size() != 0) res[$].last = 1'b1;
    foreach (res[i]) pending_lits.push_back(res[i]);
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // Offers one character beat and predicts it once taken
  task automatic send_beat(input logic [CharW-1:0] ch, input logic eoi);
    int unsigned gap;
    gap = (no_gaps || $urandom_range(0, 9) > 2) ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.character    <= ch;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    lex_char(ch, eoi);
    n_beats++;
  endtask

  // tab_width only changes once every result is out and the pipe is empty
  task automatic write_tab(input logic [TabW-1:0] w);
    in_ch.valid <= 1'b0;
    while (pending_lits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.tab_width <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tab_cur = w;
    n_cfg++;
  endtask

  function automatic logic [CharW-1:0] rand_digit(input radix_e r);
    int unsigned v;
    v = $urandom_range(0, (r == RADIX_HEX) ? 15 : (r == RADIX_DEC) ? 9 : 7);
    if (v < 10) return CharW'(ChZero + v);
    return $urandom_range(0, 1) ? CharW'("a" + v - 10) : CharW'("A" + v - 10);
  endfunction

  function automatic logic [CharW-1:0] rand_ws();
    case ($urandom_range(0, 3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChCr;
      default: return ChLf;
    endcase
  endfunction

  function automatic logic [CharW-1:0] rand_illegal();
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(0, 255)); while (is_ws(c) || (c >= "0" && c <= "9"));
    return c;
  endfunction

  // Literal with random digits (a hex one may get none); a few run long enough to wrap
  task automatic send_literal();
    radix_e      kind;
    int unsigned len;
    kind = radix_e'($urandom_range(0, 2));
    len  = ($urandom_range(0, 19) < 17) ? $urandom_range(0, 5) : $urandom_range(15, 24);
    case (kind)
      RADIX_DEC: send_beat(CharW'(ChZero + $urandom_range(1, 9)), 1'b0);
      RADIX_OCT: send_beat(ChZero, 1'b0);
      default: begin
        send_beat(ChZero, 1'b0);
        send_beat($urandom_range(0, 1) ? ChX : ChXUp, 1'b0);
      end
    endcase
    repeat (len) send_beat(rand_digit(kind), 1'b0);
  endtask

  task automatic send_terminator();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)      repeat ($urandom_range(1, 3)) send_beat(rand_ws(), 1'b0);
    else if (r < 80) send_beat(rand_illegal(), 1'b0);
    else if (r < 90) send_beat(CharW'($urandom_range(0, 255)), 1'b1);
    else             send_beat($urandom_range(0, 1) ? "8" : "9", 1'b0);
  endtask

  // Mostly token streams, with noise and broken tokens mixed in
  task automatic random_phase(input int unsigned n);
    int unsigned target;
    int unsigned r;
    target = n_beats + n;
    while (n_beats < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_literal();
        send_terminator();
      end else if (r < 80) begin
        send_beat(rand_illegal(), 1'b0);
      end else if (r < 88) begin
        send_beat(CharW'($urandom_range(0, 255)), 1'b0);
      end else if (r < 94) begin
        send_beat(rand_ws(), 1'b0);
      end else begin
        send_beat(CharW'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  // Result side: random stalls, plus the long hold-off when asked
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(input string what, input logic [ValueW-1:0] want,
                             input logic [ValueW-1:0] got);
    if (want !== got) begin
      $display("%t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      n_fail++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    lit_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.is_error === 1'b1) n_err_out++;
      if (pending_lits.size() == 0) begin
        $display("%t: unexpected result: expected none, actual value %h error %b line %0d col %0d",
                 $time, out_ch.value, out_ch.is_error, out_ch.line_number,
                 out_ch.column_number);
        n_fail++;
      end else begin
        want = pending_lits.pop_front();
        check_field("value", want.value, out_ch.value);
        check_field("is_error", ValueW'(want.is_error), ValueW'(out_ch.is_error));
        check_field("line_number", ValueW'(want.line), ValueW'(out_ch.line_number));
        check_field("column_number", ValueW'(want.col), ValueW'(out_ch.column_number));
        check_field("last", ValueW'(want.last), ValueW'(out_ch.last));
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    dir_row_t row;
    rst_n = 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.character    <= '0;
    in_ch.end_of_input <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.tab_width   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset tab width
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      send_beat(row.ch, row.eoi);
      if (row.typed) begin
        if (pending_lits.size() == 0) begin
          $display("%t: directed row %0d: expected value %h error %b line %0d col %0d,",
                   $time, i, row.value, row.is_error, row.line, row.col);
          $display("  actual no result");
          n_fail++;
        end else if (pending_lits[$].value !== row.value ||
                     pending_lits[$].is_error !== row.is_error ||
                     pending_lits[$].line !== row.line ||
                     pending_lits[$].col !== row.col) begin
          $display("%t: directed row %0d: expected value %h error %b line %0d col %0d,",
                   $time, i, row.value, row.is_error, row.line, row.col);
          $display("  actual value %h error %b line %0d col %0d",
                   pending_lits[$].value, pending_lits[$].is_error,
                   pending_lits[$].line, pending_lits[$].col);
          n_fail++;
        end
      end
    end

    write_tab('0);
    random_phase(400);

    // long hold-off on the result side so the input backs up
    write_tab('1);
    hold_left = HOLD_CYCLES;
    random_phase(400);

    // a stretch with no idling on either side
    no_gaps = 1'b1;
    write_tab(TabW'($urandom_range(1, 14)));
    random_phase(250);
    no_gaps = 1'b0;

    write_tab(TabW'($urandom_range(0, 15)));
    random_phase(575);

    in_ch.valid <= 1'b0;
    while (pending_lits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters over %0d tab-width settings; %s %0d results, %0d of them errors.",
             n_beats, n_cfg + 1, "checked", n_results, n_err_out);
    $display("Mismatches: %0d", n_fail);
    if (n_fail == 0) begin
      $display("number_literal_scanner_top regression: pass");
    end else begin
      $display("number_literal_scanner_top regression: fail");
    end
    $finish;
  end

endmodule
